@@ sv/hcbp_pkg.sv @@
// types and constants of the huffman code bit packer
package hcbp_pkg;

	localparam int BYTE_W       = 8;
	localparam int SYM_IN_W     = 8;
	localparam int PATTERN_W    = 32;
	localparam int LEN_W        = 6;
	localparam int VALID_W      = 4;
	localparam int IN_TDATA_W   = 48;
	localparam int OUT_TDATA_W  = 16;
	localparam int CMD_W        = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_FLUSH  = 2'd2
	} cmd_t;

	// item in the table read stage
	typedef struct packed {
		logic cmd_load;
		logic cmd_encode;
		logic cmd_flush;
		logic pad;
		logic len_err;
		logic entry_ok;
	} s1_ctl_t;

endpackage

@@ sv/huffman_code_bit_packer_top.sv @@
// table-driven huffman encoder that packs code bits into bytes
//
// channel   dir  tdata                                           tuser      tlast
// s_axis    in   symbol, code_pattern, code_length, pad_after    command    -
// m_axis    out  out_byte, valid_bits                            error_flag last_of_run
//
// an item is read from the code memory into a register and merged into the byte
// packer once the packer is free and m_axis can accept; the packer sends one byte
// per cycle while m_axis is not stalled
// reset clears the entry valid bits, so every table entry reads as length zero
// a stall on m_axis holds the packer, and input is taken again once the
// read stage can hand its item on
module huffman_code_bit_packer_top #(
	parameter int MAX_CODE_LEN = 32,
	parameter int SYMBOL_COUNT = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// symbol [7:0], code_pattern [39:8], code_length [45:40], pad_after [46], zero [47]
	input  logic [hcbp_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// command [1:0]
	input  logic [hcbp_pkg::CMD_W-1:0]      s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// out_byte [7:0], valid_bits [11:8], zero [15:12]
	output logic [hcbp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// error_flag
	output logic                            m_axis_tuser,
	output logic                            m_axis_tlast
);
	import hcbp_pkg::*;

	localparam int CODE_W = (MAX_CODE_LEN > 32) ? 32 : MAX_CODE_LEN;
	localparam int ACC_W  = CODE_W + BYTE_W;
	localparam int CNT_W  = $clog2(ACC_W + 1);
	localparam int SYM_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int WORD_W = LEN_W + CODE_W;

	// input fields
	logic [SYM_IN_W-1:0]  in_symbol;
	logic [PATTERN_W-1:0] in_pattern;
	logic [LEN_W-1:0]     in_length;
	logic                 in_pad;
	logic [CMD_W-1:0]     in_cmd;

	assign in_symbol  = s_axis_tdata[SYM_IN_W-1:0];
	assign in_pattern = s_axis_tdata[SYM_IN_W +: PATTERN_W];
	assign in_length  = s_axis_tdata[SYM_IN_W+PATTERN_W +: LEN_W];
	assign in_pad     = s_axis_tdata[SYM_IN_W+PATTERN_W+LEN_W];
	assign in_cmd     = s_axis_tuser;

	logic             s_acc;
	logic             in_range;
	logic             len_err;
	logic             wr_en;
	logic [SYM_W-1:0] sym_idx;
	logic [LEN_W-1:0] align_sh;
	logic [CODE_W-1:0] code_al;

	assign s_acc    = s_axis_tvalid && s_axis_tready;
	assign in_range = ({1'b0, in_symbol} < (SYM_IN_W+1)'(SYMBOL_COUNT));
	assign sym_idx  = in_symbol[SYM_W-1:0];
	assign len_err  = (in_length > LEN_W'(CODE_W));
	assign wr_en    = s_acc && (in_cmd == CMD_LOAD) && in_range && !len_err;
	// codes are stored left aligned so the packer only shifts by its fill
	assign align_sh = LEN_W'(CODE_W) - in_length;
	assign code_al  = in_pattern[CODE_W-1:0] << align_sh;

	// code memory and entry valid bits
	logic [WORD_W-1:0]       mem [SYMBOL_COUNT];
	logic [WORD_W-1:0]       rd_s1;
	logic [SYMBOL_COUNT-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[sym_idx] <= {in_length, code_al};
		end
		if (s_acc) begin
			rd_s1 <= mem[sym_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[sym_idx] <= 1'b1;
		end
	end

	// read stage control
	logic    s1_valid_q;
	s1_ctl_t s1_ctl_s1;
	logic    s1_vld_s1;
	logic    take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_acc) begin
			s1_valid_q <= 1'b1;
		end else if (take) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			s1_ctl_s1.cmd_load   <= (in_cmd == CMD_LOAD);
			s1_ctl_s1.cmd_encode <= (in_cmd == CMD_ENCODE);
			s1_ctl_s1.cmd_flush  <= (in_cmd == CMD_FLUSH);
			s1_ctl_s1.pad        <= in_pad;
			s1_ctl_s1.len_err    <= len_err;
			s1_ctl_s1.entry_ok   <= in_range;
			s1_vld_s1            <= in_range && vld_q[sym_idx];
		end
	end

	assign s_axis_tready = !s1_valid_q || take;

	// byte packer
	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pend_q;
	logic             m_valid_q;
	logic [BYTE_W-1:0]  m_byte_q;
	logic [VALID_W-1:0] m_bits_q;
	logic             m_last_q;
	logic             m_err_q;

	logic               out_ok;
	logic               free;
	logic [LEN_W-1:0]   len_eff;
	logic [CODE_W-1:0]  code_eff;
	logic [ACC_W-1:0]   src_acc;
	logic [CNT_W-1:0]   src_cnt;
	logic               src_pend;
	logic [CNT_W-1:0]   rem_cnt;
	logic               emit_err;
	logic               emit_byte;
	logic [ACC_W-1:0]   nxt_acc;
	logic [CNT_W-1:0]   nxt_cnt;
	logic               nxt_pend;
	logic [BYTE_W-1:0]  o_byte;
	logic [VALID_W-1:0] o_bits;
	logic               o_last;

	always_comb begin
		out_ok   = !m_valid_q || m_axis_tready;
		free     = !((cnt_q >= CNT_W'(BYTE_W)) || (pend_q && (cnt_q != '0)));
		take     = s1_valid_q && free && out_ok;
		len_eff  = (s1_ctl_s1.cmd_encode && s1_vld_s1) ? rd_s1[CODE_W +: LEN_W] : '0;
		code_eff = (len_eff != '0) ? rd_s1[CODE_W-1:0] : '0;

		src_acc  = acc_q;
		src_cnt  = cnt_q;
		src_pend = pend_q;
		emit_err = 1'b0;
		if (take) begin
			src_pend = 1'b0;
			emit_err = s1_ctl_s1.cmd_load && s1_ctl_s1.entry_ok && s1_ctl_s1.len_err;
			if (s1_ctl_s1.cmd_encode) begin
				// append the new code just below the bits already held
				src_acc  = acc_q | ({code_eff, {BYTE_W{1'b0}}} >> cnt_q);
				src_cnt  = cnt_q + CNT_W'(len_eff);
				src_pend = s1_ctl_s1.pad;
			end else if (s1_ctl_s1.cmd_flush) begin
				src_pend = 1'b1;
			end
		end

		rem_cnt   = src_cnt - CNT_W'(BYTE_W);
		emit_byte = out_ok && !emit_err &&
			((src_cnt >= CNT_W'(BYTE_W)) || (src_pend && (src_cnt != '0)));

		nxt_acc  = src_acc;
		nxt_cnt  = src_cnt;
		nxt_pend = src_pend;
		o_byte   = src_acc[ACC_W-1 -: BYTE_W];
		o_bits   = VALID_W'(BYTE_W);
		o_last   = 1'b1;
		if (emit_err) begin
			o_byte = '0;
			o_bits = '0;
		end else if (src_cnt >= CNT_W'(BYTE_W)) begin
			nxt_acc = src_acc << BYTE_W;
			nxt_cnt = rem_cnt;
			o_last  = (rem_cnt < CNT_W'(BYTE_W)) && !(src_pend && (rem_cnt != '0));
		end else begin
			// padded partial byte, low bits are already zero
			o_bits = VALID_W'(src_cnt);
			if (emit_byte) begin
				nxt_acc  = '0;
				nxt_cnt  = '0;
				nxt_pend = 1'b0;
			end
		end
		if (!emit_byte) begin
			nxt_acc = src_acc;
			nxt_cnt = src_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			cnt_q     <= '0;
			pend_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			acc_q  <= nxt_acc;
			cnt_q  <= nxt_cnt;
			pend_q <= nxt_pend;
			if (emit_byte || emit_err) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_byte || emit_err) begin
			m_byte_q <= o_byte;
			m_bits_q <= o_bits;
			m_last_q <= o_last;
			m_err_q  <= emit_err;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-BYTE_W-VALID_W){1'b0}}, m_bits_q, m_byte_q};
	assign m_axis_tuser  = m_err_q;
	assign m_axis_tlast  = m_last_q;

endmodule

@@ sim/huffman_code_bit_packer_top_tb.sv @@
// testbench for the huffman code bit packer: directed table, then random traffic
`timescale 1ns / 1ps

module huffman_code_bit_packer_top_tb;
	import hcbp_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam int CODE_LEN_MAX = 32;
	localparam int RANDOM_ITEMS = 480;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DIR_ROWS = 24;

	typedef struct packed {
		logic [BYTE_W-1:0]  out_byte;
		logic [VALID_W-1:0] valid_bits;
		logic               last_of_run;
		logic               error_flag;
	} packed_byte_t;

	typedef struct packed {
		logic [CMD_W-1:0]     cmd;
		logic [SYM_IN_W-1:0]  sym;
		logic [PATTERN_W-1:0] pat;
		logic [LEN_W-1:0]     len;
		logic                 pad;
		logic                 typed;
		logic                 has_res;
		packed_byte_t         res;
	} stim_row_t;

	localparam packed_byte_t NO_BYTE = '0;
	localparam packed_byte_t LEN_ERR = '{8'h00, 4'd0, 1'b1, 1'b1};

	// rows with typed set carry their own answer; the rest go through the predictor
	stim_row_t dir_rows [DIR_ROWS] = '{
		'{CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b1, 1'b0, NO_BYTE},
		'{CMD_LOAD,   8'h00, 32'hffff_ffff, 6'd0,  1'b0, 1'b1, 1'b0, NO_BYTE},
		'{CMD_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b1, 1'b1, 1'b0, NO_BYTE},
		'{CMD_LOAD,   8'hff, 32'hffff_ffff, 6'd32, 1'b0, 1'b1, 1'b0, NO_BYTE},
		'{CMD_ENCODE, 8'hff, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 1'b0, NO_BYTE},
		'{CMD_LOAD,   8'h01, 32'hffff_ffff, 6'd33, 1'b1, 1'b1, 1'b1, LEN_ERR},
		'{CMD_LOAD,   8'h02, 32'h0000_0000, 6'd63, 1'b0, 1'b1, 1'b1, LEN_ERR},
		'{CMD_LOAD,   8'h01, 32'h0000_0001, 6'd1,  1'b0, 1'b1, 1'b0, NO_BYTE},
		'{CMD_ENCODE, 8'h01, 32'hffff_ffff, 6'd63, 1'b0, 1'b0, 1'b0, NO_BYTE},
		'{CMD_ENCODE, 8'hff, 32'h0000_0000, 6'd0,  1'b1, 1'b0, 1'b0, NO_BYTE},
		'{CMD_LOAD,   8'h03, 32'h0000_0005, 6'd3,  1'b1, 1'b1, 1'b0, NO_BYTE},
		'{CMD_ENCODE, 8'h03, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 1'b0, NO_BYTE},
		'{CMD_FLUSH,  8'hff, 32'hffff_ffff, 6'd63, 1'b1, 1'b0, 1'b0, NO_BYTE},
		'{CMD_SPARE,  8'hff, 32'hffff_ffff, 6'd63, 1'b1, 1'b1, 1'b0, NO_BYTE},
		'{CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b1, 1'b0, NO_BYTE},
		'{CMD_LOAD,   8'h04, 32'haaaa_aaaa, 6'd7,  1'b1, 1'b1, 1'b0, NO_BYTE},
		'{CMD_LOAD,   8'h05, 32'h0000_0000, 6'd1,  1'b0, 1'b1, 1'b0, NO_BYTE},
		'{CMD_ENCODE, 8'h04, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 1'b0, NO_BYTE},
		'{CMD_ENCODE, 8'h05, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 1'b0, NO_BYTE},
		'{CMD_ENCODE, 8'h05, 32'h0000_0000, 6'd0,  1'b1, 1'b0, 1'b0, NO_BYTE},
		'{CMD_LOAD,   8'h80, 32'h1234_5678, 6'd32, 1'b0, 1'b1, 1'b0, NO_BYTE},
		'{CMD_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  1'b1, 1'b0, 1'b0, NO_BYTE},
		'{CMD_ENCODE, 8'h03, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 1'b0, NO_BYTE},
		'{CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 1'b0, 1'b0, NO_BYTE}
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [CMD_W-1:0]       s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   m_axis_tlast;

	// predictor state
	logic [PATTERN_W-1:0] code_mem [256] = '{default: '0};
	logic [LEN_W-1:0]     len_mem [256] = '{default: '0};
	logic [BYTE_W-1:0]    acc_byte = '0;
	int                   fill_pos = 7;
	bit                   written [256];
	logic [SYM_IN_W-1:0]  loaded_syms [$];

	packed_byte_t step_bytes [$];
	packed_byte_t pending_bytes [$];
	packed_byte_t head;

	bit  calm = 1'b0;
	int  mismatches = 0;
	int  items_sent = 0;
	int  bytes_checked = 0;
	int  len_errors = 0;
	int  cycles = 0;

	huffman_code_bit_packer_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= calm || ($urandom_range(0, 99) >= 33);
	end

	function automatic void put_byte(int nbits);
		packed_byte_t b;
		b = '{acc_byte, nbits[VALID_W-1:0], 1'b0, 1'b0};
		step_bytes.insert(step_bytes.size(), b);
		acc_byte = '0;
		fill_pos = 7;
	endfunction

	// packs one item into the byte buffer and collects the bytes it gives out
	function automatic void pack_code_bits(logic [CMD_W-1:0] cmd, logic [SYM_IN_W-1:0] sym,
			logic [PATTERN_W-1:0] pat, logic [LEN_W-1:0] len, logic pad);
		step_bytes.delete();
		case (cmd)
			CMD_LOAD: begin
				if (len > CODE_LEN_MAX) begin
					step_bytes.insert(step_bytes.size(), LEN_ERR);
				end else begin
					code_mem[sym] = pat;
					len_mem[sym] = len;
				end
			end
			CMD_ENCODE: begin
				for (int i = int'(len_mem[sym]); i > 0; i--) begin
					acc_byte[fill_pos] = code_mem[sym][i-1];
					if (fill_pos == 0)
						put_byte(8);
					else
						fill_pos--;
				end
				if (pad && fill_pos != 7)
					put_byte(7 - fill_pos);
			end
			CMD_FLUSH: begin
				if (fill_pos != 7)
					put_byte(7 - fill_pos);
			end
			default: ;
		endcase
		if (step_bytes.size() != 0)
			step_bytes[$].last_of_run = 1'b1;
	endfunction

	// one transfer on s_axis, then the predictor for it
	task automatic issue(logic [CMD_W-1:0] cmd, logic [SYM_IN_W-1:0] sym,
			logic [PATTERN_W-1:0] pat, logic [LEN_W-1:0] len, logic pad, bit use_model);
		if (!calm && $urandom_range(0, 99) < 33) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 33);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, pad, len, pat, sym};
		s_axis_tuser <= cmd;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
		pack_code_bits(cmd, sym, pat, len, pad);
		if (cmd == CMD_LOAD && len <= CODE_LEN_MAX && !written[sym]) begin
			written[sym] = 1'b1;
			loaded_syms.insert(loaded_syms.size(), sym);
		end
		if (use_model)
			foreach (step_bytes[k]) pending_bytes.insert(pending_bytes.size(), step_bytes[k]);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			bytes_checked++;
			if (pending_bytes.size() == 0) begin
				$error("unexpected transfer: out_byte %02h valid_bits %0d",
					m_axis_tdata[7:0], m_axis_tdata[11:8]);
				mismatches++;
			end else begin
				head = pending_bytes.pop_front();
				if (head.error_flag)
					len_errors++;
				if (m_axis_tdata[7:0] !== head.out_byte) begin
					$error("out_byte: expected %02h, got %02h", head.out_byte, m_axis_tdata[7:0]);
					mismatches++;
				end
				if (m_axis_tdata[11:8] !== head.valid_bits) begin
					$error("valid_bits: expected %0d, got %0d", head.valid_bits,
						m_axis_tdata[11:8]);
					mismatches++;
				end
				if (m_axis_tlast !== head.last_of_run) begin
					$error("last_of_run: expected %0b, got %0b", head.last_of_run, m_axis_tlast);
					mismatches++;
				end
				if (m_axis_tuser !== head.error_flag) begin
					$error("error_flag: expected %0b, got %0b", head.error_flag, m_axis_tuser);
					mismatches++;
				end
			end
		end
	end

	initial begin
		logic [CMD_W-1:0]     cmd;
		logic [SYM_IN_W-1:0]  sym;
		logic [PATTERN_W-1:0] pat;
		logic [LEN_W-1:0]     len;
		int                   r;
		int                   r2;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			issue(dir_rows[i].cmd, dir_rows[i].sym, dir_rows[i].pat, dir_rows[i].len,
				dir_rows[i].pad, !dir_rows[i].typed);
			if (dir_rows[i].typed && dir_rows[i].has_res)
				pending_bytes.insert(pending_bytes.size(), dir_rows[i].res);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= 150 && n < 260);
			// hold the sender until the packer has drained
			if (n == 320) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_bytes.size() != 0) @(posedge clk);
			end
			r = int'($urandom_range(0, 99));
			r2 = int'($urandom_range(0, 99));
			pat = $urandom;
			len = LEN_W'($urandom_range(0, 63));
			if (r < 25) begin
				cmd = CMD_LOAD;
				sym = ($urandom_range(0, 1) != 0) ? SYM_IN_W'($urandom_range(0, 255)) :
					SYM_IN_W'($urandom_range(0, 15));
				if (r2 < 8)
					len = LEN_W'($urandom_range(33, 63));
				else if (r2 < 14)
					len = '0;
				else if (r2 < 50)
					len = LEN_W'($urandom_range(1, 8));
				else
					len = LEN_W'($urandom_range(1, 32));
			end else if (r < 80) begin
				cmd = CMD_ENCODE;
				sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
			end else if (r < 93) begin
				cmd = CMD_FLUSH;
				sym = SYM_IN_W'($urandom_range(0, 255));
			end else begin
				cmd = CMD_SPARE;
				sym = SYM_IN_W'($urandom_range(0, 255));
			end
			issue(cmd, sym, pat, len,
				(cmd == CMD_ENCODE) ? ($urandom_range(0, 4) == 0) : 1'($urandom_range(0, 1)),
				1'b1);
		end
		calm = 1'b0;
		s_axis_tvalid <= 1'b0;

		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("run covered %0d input items and %0d output bytes", items_sent, bytes_checked);
		$display("%0d overlong loads flagged, %0d symbols held a code", len_errors,
			loaded_syms.size());
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
